[rtl/mcma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average: shared types and constants
// Field widths, channel order, register indexes and the control structs that
// pass between the top level and the serial divide unit.
// ----------------------------------------------------------------------------
package mcma_pkg;

  localparam int DATA_W     = 16;  // every field is unsigned Q12.4
  localparam int NUM_FIELDS = 9;   // sensor fields in one sample set
  localparam int SPEED_FIELD = 1;
  localparam int POWER_FIELD = 2;

  // Miles per kilometre as an unsigned Q0.16 fraction.
  localparam logic [DATA_W-1:0] MILES_PER_KM_Q16 = 16'd40723;

  // Configuration port.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_UNITS  = 1'b1;

  typedef logic [DATA_W-1:0] sample_t;

  // Request to the divide unit: start one channel, optionally rescale speed.
  typedef struct packed {
    logic start;
    logic convert;
  } div_req_t;

  // Answer from the divide unit: a one-cycle done strobe with the result.
  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

[rtl/mcma_div_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divide and scale unit
// Restoring division of a running sum by the window, one quotient bit per
// cycle, followed when asked by a bit-serial multiply by miles per km.
// ----------------------------------------------------------------------------
module mcma_div_scale import mcma_pkg::*; #(
  parameter int SUM_W = 24,
  parameter int WIN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WIN_W-1:0] divisor,
  output div_rsp_t         rsp
);

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {DS_IDLE, DS_DIV, DS_MUL} ds_state_t;

  ds_state_t        state;
  logic [SUM_W-1:0] quo;
  logic [WIN_W-1:0] rem;
  logic [DATA_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             convert;

  logic [WIN_W:0]   shifted;
  logic [WIN_W:0]   diff;
  logic             fits;
  logic [WIN_W-1:0] rem_next;
  logic [SUM_W-1:0] quo_next;
  logic [DATA_W:0]  acc_sum;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted  = {rem, quo[SUM_W-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = (shifted >= {1'b0, divisor});
    rem_next = fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
    quo_next = {quo[SUM_W-2:0], fits};
    // Shift-right accumulate keeps the product floored to Q12.4 at every step.
    acc_sum  = {1'b0, acc} + (quo[0] ? {1'b0, MILES_PER_KM_Q16} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DS_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        DS_IDLE: begin
          if (req.start) begin
            quo     <= dividend;
            rem     <= '0;
            cnt     <= CNT_W'(SUM_W - 1);
            convert <= req.convert;
            state   <= DS_DIV;
          end
        end
        DS_DIV: begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (convert) begin
              acc   <= '0;
              cnt   <= CNT_W'(DATA_W - 1);
              state <= DS_MUL;
            end else begin
              rsp.quotient <= quo_next[DATA_W-1:0];
              rsp.done     <= 1'b1;
              state        <= DS_IDLE;
            end
          end
        end
        DS_MUL: begin
          quo <= quo >> 1;
          acc <= acc_sum[DATA_W:1];
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            rsp.quotient <= acc_sum[DATA_W:1];
            rsp.done     <= 1'b1;
            state        <= DS_IDLE;
          end
        end
        default: state <= DS_IDLE;
      endcase
    end
  end

endmodule

[rtl/multichannel_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average
// Boxcar average over the last window_length sample sets of nine sensor
// channels, with an optional km/h to mph conversion of the speed channel.
// ----------------------------------------------------------------------------
// Usage. A sample set arrives as one transaction on the sample channel
// (sample_valid / sample_stall); the averaged set, together with the raw
// power value, leaves as one transaction on the result channel
// (result_valid / result_stall). Configuration is written through cfg_write,
// cfg_index and cfg_data while the block is idle.
//
// Timing. The channels are handled one after another through a single serial
// divider that yields one quotient bit per clock, followed by the serial mph
// multiply for the speed channel when imperial units are selected. With a
// window of zero the raw values skip the divider and go straight to the
// output register. One set is in work at a time; sample_stall is high from
// acceptance until the result is registered.
//
// Reset and stalls. Reset sets a window of one and metric units, and empties
// the history. Writing the window empties the history again. The ring memory
// is never swept: a fill count marks which ring entries have been written
// since the history was emptied, and unwritten entries read as zero. While
// the receiver stalls, the result is held and the next set may still be
// accepted and processed; its result waits until the output register frees.
// ----------------------------------------------------------------------------
module multichannel_moving_average import mcma_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int CHANNELS   = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Sample channel
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              heart_rate,
  input  sample_t              speed,
  input  sample_t              power,
  input  sample_t              alt_power,
  input  sample_t              cadence,
  input  sample_t              muscle_oxygen,
  input  sample_t              total_hemoglobin,
  input  sample_t              oxy_hemoglobin,
  input  sample_t              deoxy_hemoglobin,
  // Result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output sample_t              smooth_heart_rate,
  output sample_t              smooth_speed,
  output sample_t              smooth_power,
  output sample_t              smooth_alt_power,
  output sample_t              smooth_cadence,
  output sample_t              smooth_muscle_oxygen,
  output sample_t              smooth_total_hemoglobin,
  output sample_t              smooth_oxy_hemoglobin,
  output sample_t              smooth_deoxy_hemoglobin,
  output sample_t              raw_power
);

  // Channels that are actually averaged; any further fields pass through.
  localparam int NCH   = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;
  localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ROW_W = NCH * DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SUM, ST_WAIT, ST_COMMIT, ST_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  window_length;
  logic              metric_units;
  logic [POS_W-1:0]  pos;       // shared ring position
  logic [WIN_W-1:0]  fill;      // ring entries written since the last clear
  logic [POS_W-1:0]  cur_pos;   // position used by the set in work
  logic [CH_W-1:0]   ch;
  logic              bypass;
  logic [SUM_W-1:0]  sums [NCH];
  sample_t           samp [NCH];   // new samples, rotated one per channel
  sample_t           old  [NCH];   // samples leaving the window
  sample_t           res  [NCH];   // averages, shifted in one per channel
  sample_t           raw  [NUM_FIELDS];

  logic [ROW_W-1:0]  ring_mem [MAX_WINDOW];
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;

  sample_t           in_vec  [NUM_FIELDS];
  sample_t           out_vec [NUM_FIELDS];
  logic [WIN_W-1:0]  win_eff;
  logic [POS_W-1:0]  pos_eff;
  logic [WIN_W-1:0]  pos_inc;
  logic [SUM_W-1:0]  new_sum;
  logic              sample_accept;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_vec[0] = heart_rate;
  assign in_vec[1] = speed;
  assign in_vec[2] = power;
  assign in_vec[3] = alt_power;
  assign in_vec[4] = cadence;
  assign in_vec[5] = muscle_oxygen;
  assign in_vec[6] = total_hemoglobin;
  assign in_vec[7] = oxy_hemoglobin;
  assign in_vec[8] = deoxy_hemoglobin;

  // Only one set is in work at a time; the output register lets the next
  // set in while a finished result is still waiting.
  assign sample_stall  = (state != ST_IDLE);
  assign sample_accept = sample_valid && !sample_stall;

  // Window values above the ring depth act as the full ring depth.
  always_comb begin
    if (32'(window_length) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(window_length);
    end
    pos_eff = (WIN_W'(pos) >= win_eff) ? '0 : pos;
    pos_inc = WIN_W'(cur_pos) + WIN_W'(1);
  end

  // The running sum of the channel at the head of the rotation takes in the
  // new sample and drops the one that leaves the window.
  assign new_sum = sums[0] + SUM_W'(samp[0]) - SUM_W'(old[0]);

  assign div_req.start   = (state == ST_SUM);
  assign div_req.convert = (32'(ch) == SPEED_FIELD) && !metric_units;

  mcma_div_scale #(
    .SUM_W (SUM_W),
    .WIN_W (WIN_W)
  ) u_div_scale (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (new_sum),
    .divisor  (win_eff),
    .rsp      (div_rsp)
  );

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      wr_row[c*DATA_W +: DATA_W] = samp[c];
    end
  end

  // Averaged channels come from the divider unless the window is zero.
  for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_out
    if (c < NCH) begin : g_avg
      assign out_vec[c] = bypass ? raw[c] : res[c];
    end else begin : g_pass
      assign out_vec[c] = raw[c];
    end
  end

  // Ring memory: one row per position holds every channel's sample.
  always_ff @(posedge clk) begin
    rd_row <= ring_mem[pos_eff];
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMMIT) begin
      ring_mem[cur_pos] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= CFG_W'(1);
      metric_units  <= 1'b1;
      pos           <= '0;
      fill          <= '0;
      result_valid  <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        sums[c] <= '0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_accept) begin
            for (int c = 0; c < NUM_FIELDS; c++) begin
              raw[c] <= in_vec[c];
            end
            for (int c = 0; c < NCH; c++) begin
              samp[c] <= in_vec[c];
            end
            cur_pos <= pos_eff;
            ch      <= '0;
            bypass  <= (win_eff == '0);
            state   <= (win_eff == '0) ? ST_DONE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          // Entries not written since the last clear read as zero.
          for (int c = 0; c < NCH; c++) begin
            old[c] <= (WIN_W'(cur_pos) < fill) ? rd_row[c*DATA_W +: DATA_W] : '0;
          end
          state <= ST_SUM;
        end
        ST_SUM: begin
          for (int c = 0; c < NCH - 1; c++) begin
            sums[c] <= sums[c+1];
            samp[c] <= samp[c+1];
            old[c]  <= old[c+1];
          end
          sums[NCH-1] <= new_sum;
          samp[NCH-1] <= samp[0];
          old[NCH-1]  <= old[0];
          state       <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            for (int c = 0; c < NCH - 1; c++) begin
              res[c] <= res[c+1];
            end
            res[NCH-1] <= div_rsp.quotient;
            if (ch == CH_W'(NCH - 1)) begin
              state <= ST_COMMIT;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_SUM;
            end
          end
        end
        ST_COMMIT: begin
          pos <= (pos_inc >= win_eff) ? '0 : POS_W'(pos_inc);
          if (WIN_W'(cur_pos) >= fill) begin
            fill <= pos_inc;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            smooth_heart_rate       <= out_vec[0];
            smooth_speed            <= out_vec[1];
            smooth_power            <= out_vec[2];
            smooth_alt_power        <= out_vec[3];
            smooth_cadence          <= out_vec[4];
            smooth_muscle_oxygen    <= out_vec[5];
            smooth_total_hemoglobin <= out_vec[6];
            smooth_oxy_hemoglobin   <= out_vec[7];
            smooth_deoxy_hemoglobin <= out_vec[8];
            raw_power               <= raw[POWER_FIELD];
            result_valid            <= 1'b1;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Configuration must arrive only while idle (not enforced). Any window
      // write empties the history; the fill count makes the ring read zero.
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH: begin
            window_length <= cfg_data;
            pos           <= '0;
            fill          <= '0;
            for (int c = 0; c < NCH; c++) begin
              sums[c] <= '0;
            end
          end
          REG_METRIC_UNITS: metric_units <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/mcma_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average: port checker
// Watches the handshake ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mcma_checker import mcma_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input sample_t raw_power
);

  // Reset leaves the block ready and with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("block not idle after reset");

  // One sample set in work at a time.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted while previous set not finished");

  // A new result appears only at the end of a set's processing.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without a set in work");

  // A stalled result is held.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(raw_power))
    else $error("stalled result changed");

endmodule

bind multichannel_moving_average mcma_checker u_mcma_checker (.*);

[tb/sv/tb_multichannel_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average: self-checking regression bench
// Drives sample-set transactions into the averaging block, predicts every
// result transaction with an in-bench boxcar model, and compares field by
// field. A directed table covers reset state, extremes, bypass, imperial
// speed and window rewrites; random phases then sweep window sizes and units.
// ----------------------------------------------------------------------------
module tb_multichannel_moving_average import mcma_pkg::*;;

  // The block is built with its default sizes, so the bench mirrors them.
  localparam int WINDOW_CAP = 256;

  // One sample set and one result set as packed vectors, channel 0 in the
  // least significant slice. The result carries raw power in the top slice.
  typedef logic [NUM_FIELDS-1:0][DATA_W-1:0] set_t;
  typedef logic [NUM_FIELDS:0][DATA_W-1:0]   result_t;

  // Rows of the directed table are either a register write or a sample set.
  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_op_t;

  typedef struct {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;
    set_t                  smp;
    logic                  typed;  // expected result written into the table
    result_t               want;
  } stim_row_t;

  // A mixed pattern whose channels are all different, so swapped lanes show.
  localparam set_t MIXED_SET = {16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h5A5A,
                                16'hA5A5, 16'h1234, 16'hFEDC, 16'h0001};

  // Random phases: window written (or not), units and number of sets.
  // The sixth entry of the window list is replaced by a random size at run
  // time. The phase that leaves the window alone shows that a units write
  // keeps the history.
  localparam int PHASES = 7;
  localparam int unsigned PHASE_WINDOW [PHASES] = '{5, 5, 256, 0, 511, 2, 1};
  localparam bit          PHASE_SETS_WINDOW [PHASES] = '{1, 0, 1, 1, 1, 1, 1};
  localparam bit          PHASE_METRIC [PHASES] = '{1, 0, 0, 0, 1, 0, 1};
  localparam int          PHASE_ITEMS [PHASES] = '{200, 100, 300, 60, 280, 160, 100};

  // Clock and reset.
  logic clk = 1'b0;
  logic rst;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Block ports.
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              heart_rate, speed, power, alt_power, cadence;
  sample_t              muscle_oxygen, total_hemoglobin, oxy_hemoglobin;
  sample_t              deoxy_hemoglobin;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  sample_t              smooth_heart_rate, smooth_speed, smooth_power;
  sample_t              smooth_alt_power, smooth_cadence, smooth_muscle_oxygen;
  sample_t              smooth_total_hemoglobin, smooth_oxy_hemoglobin;
  sample_t              smooth_deoxy_hemoglobin, raw_power;

  multichannel_moving_average DUT (.*);

  // Shadow state of the averaging history and of the two registers.
  sample_t     history [NUM_FIELDS][WINDOW_CAP];
  int unsigned channel_total [NUM_FIELDS];
  int unsigned ring_slot;
  int unsigned window_reg;
  logic        metric_km;

  // Results still owed by the block, oldest first.
  result_t     pending_averages [$];
  stim_row_t   directed_rows [$];
  int          mismatches = 0;

  // Idling controls. Stall controls are updated with nonblocking writes so
  // the stall generator sees them only from the next edge, regardless of process order.
  logic        stall_on = 1'b0;
  logic        quiet_tail = 1'b0;
  int unsigned stall_left = 0;
  bit          gaps_on;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  task automatic forget_history();
    foreach (history[c, s]) history[c][s] = '0;
    foreach (channel_total[c]) channel_total[c] = 0;
    ring_slot = 0;
  endtask

  // Works out the result for one accepted sample set and advances the
  // shadow history exactly as the block should. Windows above the ring
  // depth behave as the full depth; a window of zero passes everything
  // through untouched, speed included.
  function automatic result_t average_set(input set_t smp);
    result_t     res;
    int unsigned win;
    int unsigned slot;
    int unsigned avg;
    win = (window_reg > WINDOW_CAP) ? WINDOW_CAP : window_reg;
    for (int c = 0; c < NUM_FIELDS; c++) res[c] = smp[c];
    res[NUM_FIELDS] = smp[POWER_FIELD];
    if (win != 0) begin
      slot = (ring_slot >= win) ? 0 : ring_slot;
      for (int c = 0; c < NUM_FIELDS; c++) begin
        // The sum always contains the sample leaving the window, so the
        // subtraction cannot wrap.
        channel_total[c] = channel_total[c] + smp[c] - history[c][slot];
        history[c][slot] = smp[c];
        avg = channel_total[c] / win;
        if (c == SPEED_FIELD && !metric_km) avg = (avg * MILES_PER_KM_Q16) >> 16;
        res[c] = avg[DATA_W-1:0];
      end
      slot++;
      ring_slot = (slot >= win) ? 0 : slot;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table construction
  // --------------------------------------------------------------------------

  task automatic add_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    stim_row_t row;
    row.op    = ROW_CONFIG;
    row.index = index;
    row.data  = data;
    row.smp   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_set(input set_t smp, input logic typed, input result_t want);
    stim_row_t row;
    row.op    = ROW_SAMPLE;
    row.index = '0;
    row.data  = '0;
    row.smp   = smp;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one sample set and holds it until the block takes it. Valid is
  // left high on return; it is only lowered where a gap follows or the sender settles.
  task automatic send_set(input set_t smp, input logic typed, input result_t want);
    result_t predicted;
    sample_valid     <= 1'b1;
    heart_rate       <= smp[0];
    speed            <= smp[SPEED_FIELD];
    power            <= smp[POWER_FIELD];
    alt_power        <= smp[3];
    cadence          <= smp[4];
    muscle_oxygen    <= smp[5];
    total_hemoglobin <= smp[6];
    oxy_hemoglobin   <= smp[7];
    deoxy_hemoglobin <= smp[8];
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    // The transaction completed at this edge, so the shadow state moves on.
    predicted = average_set(smp);
    pending_averages.push_back(typed ? want : predicted);
  endtask

  // Occasionally holds the sender back for a short burst.
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops offering sets and waits until every owed result has been taken.
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write; only called once the block has gone quiet. The strobe
  // is dropped at the next edge and is seen low before the task returns,
  // so back-to-back writes never raise and lower the strobe in the same step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (index)
      REG_WINDOW_LENGTH: begin
        // Any window write empties the history, even a rewrite of the same size.
        window_reg = data;
        forget_history();
      end
      REG_METRIC_UNITS: begin
        metric_km = data[0];
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // Random stall bursts, switched off for quiet stretches and for the tail
  // of the run.
  always @(posedge clk) begin
    if (rst || quiet_tail || !stall_on) begin
      stall_left   <= 0;
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left   <= $urandom_range(0, 5);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input sample_t due, input sample_t got);
    if (got !== due) begin
      $error("%s: expected 0x%04h, got 0x%04h", name, due, got);
      mismatches++;
    end
  endtask

  result_t due;

  // Every completed result transaction is matched against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_averages.size() == 0) begin
        $error("result transaction with no sample set outstanding");
        mismatches++;
      end else begin
        due = pending_averages.pop_front();
        check_field("smooth_heart_rate", due[0], smooth_heart_rate);
        check_field("smooth_speed", due[SPEED_FIELD], smooth_speed);
        check_field("smooth_power", due[POWER_FIELD], smooth_power);
        check_field("smooth_alt_power", due[3], smooth_alt_power);
        check_field("smooth_cadence", due[4], smooth_cadence);
        check_field("smooth_muscle_oxygen", due[5], smooth_muscle_oxygen);
        check_field("smooth_total_hemoglobin", due[6], smooth_total_hemoglobin);
        check_field("smooth_oxy_hemoglobin", due[7], smooth_oxy_hemoglobin);
        check_field("smooth_deoxy_hemoglobin", due[8], smooth_deoxy_hemoglobin);
        check_field("raw_power", due[NUM_FIELDS], raw_power);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    set_t        smp;
    result_t     want;
    int unsigned win;
    int unsigned pick;
    logic [7:0]  spare_bits;

    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    sample_valid     <= 1'b0;
    heart_rate       <= '0;
    speed            <= '0;
    power            <= '0;
    alt_power        <= '0;
    cadence          <= '0;
    muscle_oxygen    <= '0;
    total_hemoglobin <= '0;
    oxy_hemoglobin   <= '0;
    deoxy_hemoglobin <= '0;

    // Shadow copy of the reset state: a window of one in km/h.
    window_reg = 1;
    metric_km  = 1'b1;
    forget_history();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table. With a window of one the average is just the latest
    // sample, so the early rows can carry their answers directly.
    add_set('0, 1'b1, '0);
    add_set('1, 1'b1, '1);
    add_set(MIXED_SET, 1'b1, {MIXED_SET[POWER_FIELD], MIXED_SET});
    // Imperial units, with junk in the upper data bits that must be dropped.
    add_write(REG_METRIC_UNITS, 9'h1FE);
    want = '1;
    want[SPEED_FIELD] = 16'd40722;  // full-scale speed times the mile factor
    add_set('1, 1'b1, want);
    add_set('0, 1'b1, '0);
    // Bypass: raw values straight through, speed left in km/h.
    add_write(REG_WINDOW_LENGTH, 9'd0);
    add_set('1, 1'b1, '1);
    add_set(MIXED_SET, 1'b1, {MIXED_SET[POWER_FIELD], MIXED_SET});
    // Short window, then the same size rewritten, which must empty the rings.
    add_write(REG_WINDOW_LENGTH, 9'd2);
    add_set('1, 1'b0, '0);
    add_set('1, 1'b0, '0);
    add_set('0, 1'b0, '0);
    add_write(REG_WINDOW_LENGTH, 9'd2);
    add_set('1, 1'b0, '0);
    // Back to km/h and the deepest window.
    add_write(REG_METRIC_UNITS, 9'h001);
    add_write(REG_WINDOW_LENGTH, 9'd256);
    add_set('1, 1'b0, '0);
    add_set('1, 1'b0, '0);
    add_set('1, 1'b0, '0);
    add_set('1, 1'b0, '0);
    add_set('0, 1'b0, '0);
    // Windows beyond the ring depth behave as the full depth.
    add_write(REG_WINDOW_LENGTH, 9'd300);
    add_set('1, 1'b0, '0);
    add_set('1, 1'b0, '0);
    add_set(MIXED_SET, 1'b0, '0);
    add_write(REG_WINDOW_LENGTH, 9'd511);
    add_set('1, 1'b0, '0);
    add_set(MIXED_SET, 1'b0, '0);

    gaps_on = 1'b1;
    stall_on <= 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CONFIG) begin
        settle();
        write_register(directed_rows[i].index, directed_rows[i].data);
      end else begin
        maybe_gap();
        send_set(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases. Each starts from an idle block, sets its registers and
    // then streams sets whose channels mix zeros, full scale, small values
    // and arbitrary words, so sums wander across the whole range.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      // The final phase runs with neither side idling.
      quiet_tail <= (p == PHASES - 1);
      win = (p == 5) ? $urandom_range(2, 255) : PHASE_WINDOW[p];
      if (PHASE_SETS_WINDOW[p]) write_register(REG_WINDOW_LENGTH, win[CFG_W-1:0]);
      spare_bits = $urandom_range(0, 255);
      write_register(REG_METRIC_UNITS, {spare_bits, PHASE_METRIC[p]});
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        // Idling switches on and off in stretches of forty sets.
        if (n % 40 == 0) begin
          gaps_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
          stall_on <= ($urandom_range(0, 3) != 0);
        end
        // Half way through the deep-window phase the sender waits for the
        // block to drain completely before carrying on.
        if (p == 2 && n == 150) settle();
        for (int c = 0; c < NUM_FIELDS; c++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) smp[c] = '0;
          else if (pick == 1) smp[c] = '1;
          else if (pick < 4) smp[c] = sample_t'($urandom_range(0, 255));
          else smp[c] = sample_t'($urandom());
        end
        // Occasional full-scale sets; in the over-size window phase a long
        // run of them fills every ring slot, driving the sums to their peak.
        if ($urandom_range(0, 19) == 0 || (p == 4 && n < 258)) smp = '1;
        maybe_gap();
        send_set(smp, 1'b0, '0);
      end
    end

    settle();
    // Allow a full averaging pass for anything that should not be there.
    repeat (300) @(posedge clk);
    if (pending_averages.size() != 0) begin
      $error("%0d result transactions never arrived", pending_averages.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("multichannel_moving_average regression: pass");
    end else begin
      $display("multichannel_moving_average regression: fail");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs under a fifth of this.
  initial begin
    #40_000_000;
    $display("multichannel_moving_average regression: fail");
    $finish;
  end

endmodule
